FILE: hdl/tfm_pkg.sv
// Package for the trapezoid fuzzy membership block: widths, shape codes,
// config register indexes and the sine polynomial coefficients.
`timescale 1ns / 1ps
package tfm_pkg;
  localparam int SAMPLE_BITS_DEF     = 32;
  localparam int GRADE_FRAC_BITS_DEF = 15;
  localparam int FRAC_BITS           = 32;  // ramp fraction x is Q0.32
  localparam int CFG_IDX_BITS        = 3;

  typedef enum logic [1:0] {
    SHAPE_LINEAR  = 2'd0,
    SHAPE_SIGMOID = 2'd1,
    SHAPE_J       = 2'd2,
    SHAPE_RSVD    = 2'd3
  } shape_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_A     = 3'd0,
    REG_B     = 3'd1,
    REG_C     = 3'd2,
    REG_D     = 3'd3,
    REG_SHAPE = 3'd4
  } cfg_idx_t;

  // Taylor magnitudes of sin(pi/2*t), Q30: K1, K3, ... K13
  localparam logic [30:0] SIN_K [7] = '{
    31'd1686629713, 31'd693598668, 31'd85569306, 31'd5026995,
    31'd172272, 31'd3864, 31'd61
  };

  localparam logic [31:0] Q30 = 32'h4000_0000;
endpackage

FILE: hdl/tfm_if.sv
// Valid/ready channel interface carrying a generic payload.
// Depends on nothing.
`timescale 1ns / 1ps
interface tfm_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: hdl/trapezoid_fuzzy_membership.sv
// Top level of the trapezoid fuzzy membership block.
// Uses tfm_pkg, tfm_div_cell and tfm_horner_cell.
`timescale 1ns / 1ps
// Usage
// -----
// Input channel in_*: one beat per sample {sample, sample_valid}.
// Output channel out_*: one beat per sample {grade, grade_valid,
// order_error}, in input order.
// Config channel cfg_*: index 0..3 = control points A..D, 4 = shape code;
// always ready, write only while the pipeline is empty.
// Throughput: one sample per cycle while the output is not stalled. The
// path holds 53 register stages: a prepare stage, 32 divider cells (one
// quotient bit each), a squaring stage, six Horner cells plus eleven
// alignment stages, one shaping register and the output register. The
// divider chain sets the length; all shapes travel the same path.
// The j-shape reciprocal ONE*2^30/den is itself done by a second run of
// GRADE_FRAC_BITS+2 (17) division cells placed after the squaring stage.
// Stall: the whole chain advances only when the output register is empty
// or being taken, so in_ready follows out_ready plus the free output slot;
// nothing is dropped or duplicated.
// Reset (rst_n low, synchronous): all stage valid bits clear, the
// registers return to zero (linear shape), the output goes not valid.
// Order error: checked from the registers each sample, grade forced to 0.
module trapezoid_fuzzy_membership import tfm_pkg::*; #(
  parameter int SAMPLE_BITS     = SAMPLE_BITS_DEF,
  parameter int GRADE_FRAC_BITS = GRADE_FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic signed [SAMPLE_BITS-1:0] in_sample,
  input  logic                        in_sample_valid,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [GRADE_FRAC_BITS:0]    out_grade,
  output logic                        out_grade_valid,
  output logic                        out_order_error,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [CFG_IDX_BITS-1:0]     cfg_index,
  input  logic [SAMPLE_BITS-1:0]      cfg_data
);
  localparam int DW = SAMPLE_BITS + 1;     // differences fit SAMPLE_BITS+1
  localparam int GW = GRADE_FRAC_BITS + 1;
  localparam int JB = GRADE_FRAC_BITS + 2; // j quotient bits (<= 2^GF)

  // tag: [0] grade_valid [1] order_error [3:2] shape [4] edge region
  // [5] plateau (one) ; rest unused
  typedef logic [20:0] tag_t;

  logic signed [SAMPLE_BITS-1:0] a_r, b_r, c_r, d_r;
  shape_t shape_r;
  logic en;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_r <= '0; b_r <= '0; c_r <= '0; d_r <= '0; shape_r <= SHAPE_LINEAR;
    end else if (cfg_valid) begin
      case (cfg_idx_t'(cfg_index))
        REG_A:     a_r <= cfg_data;
        REG_B:     b_r <= cfg_data;
        REG_C:     c_r <= cfg_data;
        REG_D:     d_r <= cfg_data;
        REG_SHAPE: shape_r <= shape_t'(cfg_data[1:0]);
        default: ;
      endcase
    end
  end

  // ---------------- prepare stage ----------------
  logic err, in_edge, in_one, rising;
  logic [DW-1:0] dx, dw;
  always_comb begin
    err = (a_r > b_r) || (b_r > c_r) || (c_r > d_r);
    rising = in_sample < b_r;
    in_edge = 1'b0; in_one = 1'b0;
    if (in_sample_valid && !err && in_sample > a_r && in_sample < d_r) begin
      if (in_sample >= b_r && in_sample <= c_r) in_one = 1'b1;
      else in_edge = 1'b1;
    end
    if (rising) begin
      dx = DW'($signed({in_sample[SAMPLE_BITS-1], in_sample})
               - $signed({a_r[SAMPLE_BITS-1], a_r}));
      dw = DW'($signed({b_r[SAMPLE_BITS-1], b_r}) - $signed({a_r[SAMPLE_BITS-1], a_r}));
    end else begin
      dx = DW'($signed({d_r[SAMPLE_BITS-1], d_r})
               - $signed({in_sample[SAMPLE_BITS-1], in_sample}));
      dw = DW'($signed({d_r[SAMPLE_BITS-1], d_r}) - $signed({c_r[SAMPLE_BITS-1], c_r}));
    end
    if (!in_edge) begin
      dx = '0; dw = DW'(1);
    end
  end

  logic          p_vld_r;
  logic [DW-1:0] p_rem_r, p_den_r;
  tag_t          p_tag_r;
  always_ff @(posedge clk) begin
    if (!rst_n) p_vld_r <= 1'b0;
    else if (en) p_vld_r <= in_valid;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      p_rem_r <= dx;
      p_den_r <= dw;
      p_tag_r <= {15'd0, in_one, in_edge, shape_r, err, in_sample_valid};
    end
  end

  // ---------------- divider chain ----------------
  logic                 dv [FRAC_BITS+1];
  logic [DW-1:0]        dr [FRAC_BITS+1];
  logic [DW-1:0]        dd [FRAC_BITS+1];
  logic [FRAC_BITS-1:0] dq [FRAC_BITS+1];
  tag_t                 dt [FRAC_BITS+1];
  assign dv[0] = p_vld_r;
  assign dr[0] = p_rem_r;
  assign dd[0] = p_den_r;
  assign dq[0] = '0;
  assign dt[0] = p_tag_r;
  for (genvar i = 0; i < FRAC_BITS; i++) begin : g_div
    tfm_div_cell #(.W(DW)) u_cell (
      .clk, .rst_n, .en,
      .vld_in(dv[i]), .rem_in(dr[i]), .den_in(dd[i]), .q_in(dq[i]), .tag_in(dt[i]),
      .vld_out(dv[i+1]), .rem_out(dr[i+1]), .den_out(dd[i+1]), .q_out(dq[i+1]),
      .tag_out(dt[i+1])
    );
  end

  // ---------------- squaring stage ----------------
  logic [FRAC_BITS-1:0] x;
  logic [29:0] t;
  logic [31:0] u;
  logic [59:0] tt;
  logic [63:0] uu;
  assign x  = dq[FRAC_BITS];
  assign t  = x[31:2];
  assign u  = 32'(33'h1_0000_0000 - {1'b0, x}) >> 2;
  assign tt = t * t;
  assign uu = u * u;

  logic        s_vld_r;
  logic [30:0] s_y_r;
  logic [31:0] s_den_r;
  logic [63:0] s_pass_r; // [31:0] x, [52:32] tag
  always_ff @(posedge clk) begin
    if (!rst_n) s_vld_r <= 1'b0;
    else if (en) s_vld_r <= dv[FRAC_BITS];
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s_y_r    <= 31'(tt[59:30]);
      s_den_r  <= Q30 + 32'(uu[63:30]);
      s_pass_r <= {11'd0, dt[FRAC_BITS], x};
    end
  end

  // ---------------- Horner chain (sine polynomial) ----------------
  logic        hv [7];
  logic [30:0] hp [7];
  logic [30:0] hy [7];
  logic [63:0] hs [7];
  assign hv[0] = s_vld_r;
  assign hp[0] = SIN_K[6];
  assign hy[0] = s_y_r;
  assign hs[0] = s_pass_r;
  for (genvar k = 0; k < 6; k++) begin : g_hor
    tfm_horner_cell #(.K(SIN_K[5-k])) u_cell (
      .clk, .rst_n, .en,
      .vld_in(hv[k]), .p_in(hp[k]), .y_in(hy[k]), .pass_in(hs[k]),
      .vld_out(hv[k+1]), .p_out(hp[k+1]), .y_out(hy[k+1]), .pass_out(hs[k+1])
    );
  end

  // j-shape reciprocal chain runs alongside: ONE*2^30 + den/2 over den.
  // den in [2^30, 2^31]; quotient < 2^(GW). Long division cells, 32-bit den.
  localparam int JW = 33;
  logic          jv [JB+1];
  logic [JW-1:0] jr [JB+1];
  logic [JW-1:0] jd [JB+1];
  logic [FRAC_BITS-1:0] jq [JB+1];
  // numerator N = 2^(GF+30) + den/2, quotient = floor(N/den) with
  // N = R0*2^JB + L. R0 = N >> JB is about 2^28, below den, so it is the
  // starting remainder and the low bits L are fed in one per cell.
  logic [63:0] jn;
  logic [JB-1:0] jlow [JB+1];
  assign jn = (64'd1 << (GRADE_FRAC_BITS + 30)) + {33'd0, s_den_r[31:1]};
  assign jv[0] = s_vld_r;
  assign jr[0] = JW'(jn >> JB);
  assign jd[0] = {1'b0, s_den_r};
  assign jq[0] = '0;
  assign jlow[0] = jn[JB-1:0];
  for (genvar j = 0; j < JB; j++) begin : g_jdiv
    logic [JW:0] sh;
    logic ge;
    logic          v_r;
    logic [JW-1:0] r_r, d_r2;
    logic [FRAC_BITS-1:0] q_r;
    logic [JB-1:0] l_r;
    assign sh = {jr[j], jlow[j][JB-1]};
    assign ge = sh >= {1'b0, jd[j]};
    always_ff @(posedge clk) begin
      if (!rst_n) v_r <= 1'b0;
      else if (en) v_r <= jv[j];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        r_r  <= ge ? JW'(sh - {1'b0, jd[j]}) : sh[JW-1:0];
        d_r2 <= jd[j];
        q_r  <= {jq[j][FRAC_BITS-2:0], ge};
        l_r  <= {jlow[j][JB-2:0], 1'b0};
      end
    end
    assign jv[j+1] = v_r;
    assign jr[j+1] = r_r;
    assign jd[j+1] = d_r2;
    assign jq[j+1] = q_r;
    assign jlow[j+1] = l_r;
  end

  // Align: Horner path has 6 stages, j path JB; delay the Horner result to
  // match the later of the two by extending the Horner path.
  localparam int HX = JB - 6;
  logic        ev [HX+1];
  logic [30:0] ep [HX+1];
  logic [63:0] es [HX+1];
  assign ev[0] = hv[6];
  assign ep[0] = hp[6];
  assign es[0] = hs[6];
  for (genvar e = 0; e < HX; e++) begin : g_align
    logic v_r;
    logic [30:0] p_r;
    logic [63:0] s_r;
    always_ff @(posedge clk) begin
      if (!rst_n) v_r <= 1'b0;
      else if (en) v_r <= ev[e];
    end
    always_ff @(posedge clk) begin
      if (en) begin p_r <= ep[e]; s_r <= es[e]; end
    end
    assign ev[e+1] = v_r;
    assign ep[e+1] = p_r;
    assign es[e+1] = s_r;
  end

  // ---------------- shaping stage 1: s = t*p, linear product ----------------
  logic [31:0] fx;
  tag_t        ft;
  logic [29:0] ft_t;
  logic [60:0] sp;
  logic [63:0] lp;
  assign fx   = es[HX][31:0];
  assign ft   = es[HX][52:32];
  assign ft_t = fx[31:2];
  assign sp   = ft_t * ep[HX];
  assign lp   = 64'(fx) << GRADE_FRAC_BITS;

  logic        f_vld_r;
  logic [30:0] f_s_r;
  logic [GW:0] f_lin_r, f_j_r;
  tag_t        f_tag_r;
  always_ff @(posedge clk) begin
    if (!rst_n) f_vld_r <= 1'b0;
    else if (en) f_vld_r <= ev[HX];
  end
  always_ff @(posedge clk) begin
    if (en) begin
      f_s_r   <= (sp[60:30] > 31'(Q30)) ? 31'(Q30) : sp[60:30];
      f_lin_r <= (GW+1)'((lp + 64'h8000_0000) >> 32);
      f_j_r   <= (GW+1)'(jq[JB]);
      f_tag_r <= ft;
    end
  end

  // ---------------- shaping stage 2: square and select ----------------
  logic [61:0] qq;
  logic [63:0] sg;
  logic [GW:0] g;
  assign qq = f_s_r * f_s_r;
  assign sg = (64'(qq[61:30]) << GRADE_FRAC_BITS) + 64'(Q30 >> 1);
  always_comb begin
    case (shape_t'(f_tag_r[3:2]))
      SHAPE_SIGMOID: g = (GW+1)'(sg >> 30);
      SHAPE_J:       g = f_j_r;
      default:       g = f_lin_r;
    endcase
    if (g > (GW+1)'(1 << GRADE_FRAC_BITS)) g = (GW+1)'(1 << GRADE_FRAC_BITS);
    if (f_tag_r[5]) g = (GW+1)'(1 << GRADE_FRAC_BITS);
    else if (!f_tag_r[4]) g = '0;
  end

  // ---------------- output register ----------------
  assign en       = !out_valid || out_ready;
  assign in_ready = en;
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid <= 1'b0;
    else if (en) out_valid <= f_vld_r;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      out_grade       <= g[GW-1:0];
      out_grade_valid <= f_tag_r[0];
      out_order_error <= f_tag_r[1];
    end
  end
endmodule

FILE: hdl/tfm_div_cell.sv
// One restoring-division cell: while en is high, produces one quotient bit
// of x = dX*2^32/dW per cycle; passes remainder and tag to the next cell.
`timescale 1ns / 1ps
module tfm_div_cell import tfm_pkg::*; #(
  parameter int W = 33
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 vld_in,
  input  logic [W-1:0]         rem_in,
  input  logic [W-1:0]         den_in,
  input  logic [FRAC_BITS-1:0] q_in,
  input  logic [20:0]          tag_in,
  output logic                 vld_out,
  output logic [W-1:0]         rem_out,
  output logic [W-1:0]         den_out,
  output logic [FRAC_BITS-1:0] q_out,
  output logic [20:0]          tag_out
);
  logic [W:0]   sh;
  logic         ge;
  logic [W-1:0] rem_nxt;

  assign sh      = {rem_in, 1'b0};
  assign ge      = sh >= {1'b0, den_in};
  assign rem_nxt = ge ? W'(sh - {1'b0, den_in}) : sh[W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_out <= 1'b0;
    end else if (en) begin
      vld_out <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_out <= rem_nxt;
      den_out <= den_in;
      q_out   <= {q_in[FRAC_BITS-2:0], ge};
      tag_out <= tag_in;
    end
  end
endmodule

FILE: hdl/tfm_horner_cell.sv
// One Horner step of the sine polynomial: p' = K - (p*y)>>30, registered.
// Carries the fraction-derived operands and tag along the chain.
`timescale 1ns / 1ps
module tfm_horner_cell import tfm_pkg::*; #(
  parameter logic [30:0] K = 31'd0
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  logic        vld_in,
  input  logic [30:0] p_in,
  input  logic [30:0] y_in,
  input  logic [63:0] pass_in,
  output logic        vld_out,
  output logic [30:0] p_out,
  output logic [30:0] y_out,
  output logic [63:0] pass_out
);
  logic [61:0] prod;
  assign prod = p_in * y_in;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_out <= 1'b0;
    end else if (en) begin
      vld_out <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_out    <= K - prod[60:30];
      y_out    <= y_in;
      pass_out <= pass_in;
    end
  end
endmodule

FILE: hdl/tfm_checker.sv
// Port-level checker for trapezoid_fuzzy_membership, bound to the top.
// Depends on tfm_pkg.
`timescale 1ns / 1ps
module tfm_checker import tfm_pkg::*; #(
  parameter int GRADE_FRAC_BITS = GRADE_FRAC_BITS_DEF
) (
  input logic                     clk,
  input logic                     rst_n,
  input logic                     in_ready,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic [GRADE_FRAC_BITS:0] out_grade,
  input logic                     out_grade_valid,
  input logic                     out_order_error
);
  a_grade_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_grade <= (GRADE_FRAC_BITS+1)'(1 << GRADE_FRAC_BITS))
    else $error("grade above one");
  a_nodata: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_grade_valid |-> out_grade == '0)
    else $error("no-data beat with nonzero grade");
  a_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_order_error |-> out_grade == '0)
    else $error("order error beat with nonzero grade");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_grade))
    else $error("stalled beat changed");
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");
endmodule

bind trapezoid_fuzzy_membership tfm_checker #(.GRADE_FRAC_BITS(GRADE_FRAC_BITS)) u_chk (
  .clk, .rst_n, .in_ready, .out_valid, .out_ready,
  .out_grade, .out_grade_valid, .out_order_error
);

FILE: verif/tb_trapezoid_fuzzy_membership.sv
// Testbench for trapezoid_fuzzy_membership: directed and random samples
// against a local grade predictor. Uses tfm_pkg, tfm_if and the block RTL.
`timescale 1ns / 1ps
module tb_trapezoid_fuzzy_membership import tfm_pkg::*;;

  typedef struct packed {
    logic signed [31:0] sample;
    logic               sample_valid;
  } sample_beat_t;

  typedef struct packed {
    logic [15:0] grade;
    logic        grade_valid;
    logic        order_error;
  } grade_beat_t;

  typedef struct packed {
    logic [CFG_IDX_BITS-1:0] index;
    logic [31:0]             data;
  } cfg_beat_t;

  localparam logic [63:0] ONE_G = 64'd1 << 15;
  localparam logic [63:0] Q30_W = 64'd1 << 30;
  localparam int DRAIN_CYCLES = 64;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always #1 clk = ~clk;

  tfm_if #(.payload_t(sample_beat_t)) smp_ch ();
  tfm_if #(.payload_t(grade_beat_t))  grd_ch ();
  tfm_if #(.payload_t(cfg_beat_t))    cfg_ch ();

  trapezoid_fuzzy_membership dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(smp_ch.valid), .in_ready(smp_ch.ready),
    .in_sample(smp_ch.data.sample), .in_sample_valid(smp_ch.data.sample_valid),
    .out_valid(grd_ch.valid), .out_ready(grd_ch.ready),
    .out_grade(grd_ch.data.grade), .out_grade_valid(grd_ch.data.grade_valid),
    .out_order_error(grd_ch.data.order_error),
    .cfg_valid(cfg_ch.valid), .cfg_ready(cfg_ch.ready),
    .cfg_index(cfg_ch.data.index), .cfg_data(cfg_ch.data.data)
  );

  // local copy of the control registers
  logic signed [31:0] pt_a, pt_b, pt_c, pt_d;
  shape_t             edge_shape;

  grade_beat_t expected_grades[$];
  int  mismatch_count = 0;
  int  tx_idle_pct = 0;
  int  rx_idle_pct = 0;
  int  rx_hold_cycles = 0;   // long receiver hold-off, counted down below

  // ---------------------------------------------------------------------
  // Grade predictor
  // ---------------------------------------------------------------------
  // floor(num * 2^32 / den), restoring division, num < den
  function automatic logic [63:0] ramp_fraction(logic [63:0] num, logic [63:0] den);
    logic [63:0] q, r;
    q = 0;
    r = num;
    for (int i = 0; i < 32; i++) begin
      r = r << 1;
      q = q << 1;
      if (r >= den) begin
        r = r - den;
        q[0] = 1'b1;
      end
    end
    return q;
  endfunction

  // sin^2(x*pi/2) via Q30 Horner polynomial
  function automatic logic [63:0] sine_sq_grade(logic [63:0] x);
    logic [63:0] t, y, p, s, q;
    t = x >> 2;
    y = (t * t) >> 30;
    p = 64'(SIN_K[6]);
    for (int k = 5; k >= 0; k--) p = 64'(SIN_K[k]) - ((p * y) >> 30);
    s = (t * p) >> 30;
    if (s > Q30_W) s = Q30_W;
    q = (s * s) >> 30;
    return (q * ONE_G + (Q30_W >> 1)) >> 30;
  endfunction

  // 1/(1+(1-x)^2), rounded division
  function automatic logic [63:0] j_grade(logic [63:0] x);
    logic [63:0] u, v, den;
    u = ((64'd1 << 32) - x) >> 2;
    v = (u * u) >> 30;
    den = Q30_W + v;
    return ((ONE_G << 30) + (den >> 1)) / den;
  endfunction

  function automatic grade_beat_t predict_grade(sample_beat_t s);
    grade_beat_t g;
    longint a, b, c, d, v;
    logic [63:0] dx, dw, x, gr;
    a = pt_a; b = pt_b; c = pt_c; d = pt_d; v = s.sample;
    g.grade_valid = s.sample_valid;
    g.order_error = (a > b) || (b > c) || (c > d);
    gr = 0;
    if (s.sample_valid && !g.order_error) begin
      if (v <= a || v >= d) gr = 0;
      else if (v >= b && v <= c) gr = ONE_G;
      else begin
        if (v < b) begin
          dx = 64'(v - a); dw = 64'(b - a);
        end else begin
          dx = 64'(d - v); dw = 64'(d - c);
        end
        x = ramp_fraction(dx, dw);
        case (edge_shape)
          SHAPE_SIGMOID: gr = sine_sq_grade(x);
          SHAPE_J:       gr = j_grade(x);
          default:       gr = (x * ONE_G + (64'd1 << 31)) >> 32;  // linear, code 3 too
        endcase
        if (gr > ONE_G) gr = ONE_G;
      end
    end
    g.grade = gr[15:0];
    return g;
  endfunction

  // ---------------------------------------------------------------------
  // Receiver: random idling plus a commanded long hold-off
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    if (rx_hold_cycles > 0) begin
      grd_ch.ready <= 1'b0;
      rx_hold_cycles <= rx_hold_cycles - 1;
    end else begin
      grd_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Checker: each output beat against the oldest expectation
  always @(posedge clk) begin
    grade_beat_t exp_g;
    if (rst_n && grd_ch.valid && grd_ch.ready) begin
      if (expected_grades.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("ERROR: unexpected beat grade=%0d gv=%0b err=%0b",
                   grd_ch.data.grade, grd_ch.data.grade_valid, grd_ch.data.order_error);
      end else begin
        exp_g = expected_grades.pop_front();
        if (grd_ch.data.grade !== exp_g.grade ||
            grd_ch.data.grade_valid !== exp_g.grade_valid ||
            grd_ch.data.order_error !== exp_g.order_error) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("ERROR: grade exp %0d/%0b/%0b got %0d/%0b/%0b",
                     exp_g.grade, exp_g.grade_valid, exp_g.order_error,
                     grd_ch.data.grade, grd_ch.data.grade_valid,
                     grd_ch.data.order_error);
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Sender and config writer
  // ---------------------------------------------------------------------
  task automatic send_sample(logic signed [31:0] value, logic is_data);
    sample_beat_t beat;
    beat.sample = value;
    beat.sample_valid = is_data;
    while ($urandom_range(99) < tx_idle_pct) begin
      smp_ch.valid <= 1'b0;
      @(posedge clk);
    end
    smp_ch.valid <= 1'b1;
    smp_ch.data  <= beat;
    @(posedge clk);
    while (!smp_ch.ready) @(posedge clk);
    expected_grades.push_back(predict_grade(beat));
  endtask

  task automatic wait_drained();
    smp_ch.valid <= 1'b0;
    while (expected_grades.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // leaves cfg valid high; the caller drops it after the last write
  task automatic write_reg(cfg_idx_t idx, logic [31:0] value);
    cfg_beat_t beat;
    beat.index = idx;
    beat.data  = value;
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= beat;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    case (idx)
      REG_A:   pt_a = value;
      REG_B:   pt_b = value;
      REG_C:   pt_c = value;
      REG_D:   pt_d = value;
      default: edge_shape = shape_t'(value[1:0]);
    endcase
  endtask

  task automatic set_trapezoid(longint a, longint b, longint c, longint d, shape_t sh);
    wait_drained();
    write_reg(REG_A, 32'(a));
    write_reg(REG_B, 32'(b));
    write_reg(REG_C, 32'(c));
    write_reg(REG_D, 32'(d));
    write_reg(REG_SHAPE, 32'(sh));
    cfg_ch.valid <= 1'b0;
  endtask

  // mostly inside or near [A, D], some full-range noise
  function automatic logic signed [31:0] pick_sample();
    longint lo, hi, span, v;
    lo = pt_a; hi = pt_d;
    if (lo > hi) begin
      v = lo; lo = hi; hi = v;
    end
    span = hi - lo + 3;
    if ($urandom_range(9) == 0 || span > 64'hFFFF_FFF0) return $urandom;
    v = lo - 1 + longint'({$urandom, $urandom} % span);
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    return 32'(v);
  endfunction

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------
  task automatic test_reset_state();
    // all points at zero: nothing can fall strictly inside an edge
    send_sample(0, 1'b1);
    send_sample(1, 1'b1);
    send_sample(-1, 1'b1);
    send_sample(0, 1'b0);
  endtask

  task automatic test_directed_shapes();
    logic signed [31:0] pts[12] = '{-100, -99, -50, -1, 0, 50, 100, 101, 200, 299, 300, 301};
    for (int sh = 0; sh < 4; sh++) begin
      set_trapezoid(-100, 0, 100, 300, shape_t'(sh));
      foreach (pts[i]) send_sample(pts[i], 1'b1);
      send_sample(32'sh8000_0000, 1'b1);
      send_sample(32'sh7FFF_FFFF, 1'b1);
      send_sample(-50, 1'b0);  // no-data passes through
    end
  endtask

  task automatic test_extreme_points();
    set_trapezoid(-64'sd2147483648, -1, 0, 64'sd2147483647, SHAPE_SIGMOID);
    send_sample(32'sh8000_0001, 1'b1);
    send_sample(32'shC000_0000, 1'b1);
    send_sample(32'sh4000_0000, 1'b1);
    send_sample(32'sh7FFF_FFFE, 1'b1);
    set_trapezoid(-64'sd2147483648, -64'sd2147483647, 64'sd2147483646,
                  64'sd2147483647, SHAPE_J);
    send_sample(32'sh8000_0000, 1'b1);
    send_sample(0, 1'b1);
  endtask

  task automatic test_order_error();
    set_trapezoid(10, 5, 20, 30, SHAPE_LINEAR);
    send_sample(7, 1'b1);
    send_sample(7, 1'b0);  // no-data still reports the order flag
    set_trapezoid(0, 10, 30, 20, SHAPE_J);
    send_sample(25, 1'b1);
  endtask

  task automatic random_config();
    longint p[4], tmp;
    int spread;
    spread = $urandom_range(3);
    for (int i = 0; i < 4; i++) begin
      case (spread)
        0:       p[i] = $signed(32'($urandom_range(200))) - 100;
        1:       p[i] = $signed(32'($urandom_range(100000))) - 50000;
        default: p[i] = $signed($urandom);
      endcase
    end
    if ($urandom_range(7) != 0) begin  // mostly well-ordered points
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3 - i; j++)
          if (p[j] > p[j+1]) begin
            tmp = p[j]; p[j] = p[j+1]; p[j+1] = tmp;
          end
    end
    set_trapezoid(p[0], p[1], p[2], p[3], shape_t'($urandom_range(3)));
  endtask

  task automatic test_random_phases();
    for (int ph = 0; ph < 12; ph++) begin
      if (ph == 0) begin
        tx_idle_pct = 15; rx_idle_pct = 51;
      end else if (ph == 4) begin
        tx_idle_pct = 51; rx_idle_pct = 15;
      end else if (ph == 8) begin
        tx_idle_pct = 0; rx_idle_pct = 0;
      end
      random_config();
      repeat (58) send_sample(pick_sample(), $urandom_range(9) != 0);
    end
  endtask

  task automatic test_backpressure();
    tx_idle_pct = 0; rx_idle_pct = 0;
    set_trapezoid(-1000, -200, 300, 5000, SHAPE_SIGMOID);
    rx_hold_cycles = 200;  // block fills and stalls its input
    repeat (70) send_sample(pick_sample(), 1'b1);
    wait_drained();        // sender pauses until all grades are back
    repeat (10) send_sample(pick_sample(), 1'b1);
  endtask

  initial begin
    smp_ch.valid = 1'b0;
    smp_ch.data  = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data  = '0;
    grd_ch.ready = 1'b0;
    pt_a = 0; pt_b = 0; pt_c = 0; pt_d = 0;
    edge_shape = SHAPE_LINEAR;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_state();
    test_directed_shapes();
    test_extreme_points();
    test_order_error();
    test_random_phases();
    test_backpressure();

    wait_drained();
    if (mismatch_count == 0) $display("tb_trapezoid_fuzzy_membership passed");
    else $display("tb_trapezoid_fuzzy_membership failed");
    $finish;
  end

  initial begin
    #2000000;
    $display("tb_trapezoid_fuzzy_membership failed");
    $finish;
  end
endmodule
